>>> src/pwmmu_pkg.sv
// ----------------------------------------------------------------------------
// pwmmu_pkg
// Shared types and codes for the two-level page-walk mmu: beat structs,
// operation and error codes, page entry bit positions and register indexes.
// ----------------------------------------------------------------------------
package pwmmu_pkg;

    // default size of the private byte memory
    localparam longint unsigned MMU_MEM_BYTES = 64'd65536;

    // configuration port
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_WORD   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SUPER_MODE = 8'd1;

    // operation codes
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_FETCH = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    // sticky error codes
    localparam logic [2:0] ERR_NONE   = 3'd0;
    localparam logic [2:0] ERR_BOUNDS = 3'd1;
    localparam logic [2:0] ERR_USER   = 3'd2;
    localparam logic [2:0] ERR_EXEC   = 3'd3;
    localparam logic [2:0] ERR_WRITE  = 3'd4;

    // page entry layout
    localparam int PG_NUM_W      = 22;
    localparam int PG_BIT_ACTIVE = 22;
    localparam int PG_BIT_SUPER  = 23;
    localparam int PG_BIT_NOWR   = 24;
    localparam int PG_BIT_NOEX   = 25;

    // full-width physical address: page number and 12-bit offset
    localparam int PA_W = PG_NUM_W + 12;

    // request beat
    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] address;
        logic [7:0]  write_data;
    } t_mmu_req;

    // response beat
    typedef struct packed {
        logic [7:0] read_data;
        logic [2:0] error_code;
        logic       access_faulted;
    } t_mmu_rsp;

endpackage

>>> src/two_level_page_walk_mmu.sv
// ----------------------------------------------------------------------------
// two_level_page_walk_mmu
// Byte access unit with a two-level page table walk over a private memory.
// ----------------------------------------------------------------------------
// Usage:
//   request channel (i_in_valid / o_in_stall / i_in_data) takes one beat per
//   access: data read, instruction fetch, byte write or clear of the sticky
//   error. response channel (o_out_valid / i_out_stall / o_out_data) returns
//   exactly one beat per request, in order.
//   configuration writes (i_cfg_valid / o_cfg_ready) set the directory word
//   and supervisor mode; they are expected only while the unit is idle.
//   one request is worked on at a time; the walk runs through a single
//   word-wide memory with registered reads, in these steps:
//     clear:            accept, then straight to the response beat
//     paging off:       access check, byte read, response
//     paging on:        directory read, table read, access
//   the response register lets the next request be taken while a finished
//   beat still waits; a stalled response blocks only the following result.
//   after reset the memory is zeroed by a pass over every word, during
//   which o_in_stall stays high.
// ----------------------------------------------------------------------------
module two_level_page_walk_mmu
    import pwmmu_pkg::*;
#(
    parameter longint unsigned MEM_BYTES = MMU_MEM_BYTES
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_mmu_req             i_in_data,
    // response channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_mmu_rsp             o_out_data,
    // configuration channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    localparam longint unsigned WORDS = (MEM_BYTES + 64'd3) / 64'd4;
    localparam int AW = (WORDS > 64'd1) ? $clog2(WORDS) : 1;
    localparam logic [PA_W:0] MEM_LIMIT = (PA_W + 1)'(MEM_BYTES);
    localparam logic [PA_W:0] ENT_LIMIT = (PA_W + 1)'(MEM_BYTES - 64'd4);
    localparam logic [AW-1:0] LAST_WORD = AW'(WORDS - 64'd1);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DIR,
        S_DIR_WAIT,
        S_TBL,
        S_TBL_WAIT,
        S_ACC,
        S_ACC_WAIT,
        S_RESP
    } t_state;

    t_state                r_state;
    logic [31:0]           r_dir_word;
    logic                  r_super_mode;
    logic [AW-1:0]         r_clr_idx;
    logic [1:0]            r_op;
    logic [31:0]           r_laddr;
    logic [7:0]            r_wdata;
    logic [PG_NUM_W-1:0]   r_page;
    logic [PA_W-1:0]       r_paddr;
    logic                  r_is_super;
    logic                  r_no_write;
    logic                  r_no_exec;
    logic [7:0]            r_res_data;
    logic [2:0]            r_res_err;
    logic [2:0]            r_err_status;
    logic [31:0]           r_rd_data;

    // word-wide byte memory
    logic [31:0]           mem [WORDS];

    logic [PA_W-1:0]       dir_addr;
    logic [PA_W-1:0]       tbl_addr;
    logic                  dir_ok;
    logic                  tbl_ok;
    logic                  pa_ok;
    logic                  user_fault;
    logic                  exec_fault;
    logic                  acc_is_write;
    logic                  rd_en;
    logic [AW-1:0]         rd_idx;
    logic                  wr_en;
    logic                  out_free;
    logic [2:0]            n_err_status;

    // entry addresses are page * 4 KiB + index * 4, built by concatenation
    assign dir_addr = {r_dir_word[PG_NUM_W-1:0], r_laddr[31:22], 2'b00};
    assign tbl_addr = {r_page, r_laddr[21:12], 2'b00};
    assign dir_ok   = ({1'b0, dir_addr} <= ENT_LIMIT);
    assign tbl_ok   = ({1'b0, tbl_addr} <= ENT_LIMIT);
    assign pa_ok    = ({1'b0, r_paddr} < MEM_LIMIT);

    // permission checks for the final access
    assign acc_is_write = (r_op == OP_WRITE);
    assign user_fault   = !r_super_mode && r_is_super;
    assign exec_fault   = (r_op == OP_FETCH) && r_no_exec;

    // memory port control
    always_comb begin
        rd_en  = 1'b0;
        rd_idx = r_paddr[AW+1:2];
        wr_en  = 1'b0;
        unique case (r_state)
            S_DIR: begin
                rd_en  = dir_ok;
                rd_idx = dir_addr[AW+1:2];
            end
            S_TBL: begin
                rd_en  = tbl_ok;
                rd_idx = tbl_addr[AW+1:2];
            end
            S_ACC: begin
                if (acc_is_write) begin
                    wr_en = !r_no_write && pa_ok;
                end else begin
                    rd_en = !user_fault && !exec_fault && pa_ok;
                end
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    // memory array: clearing pass, byte writes, registered word reads
    always_ff @(posedge i_clk) begin
        if (r_state == S_CLEAR) begin
            mem[r_clr_idx] <= '0;
        end else if (wr_en) begin
            mem[r_paddr[AW+1:2]][8*r_paddr[1:0] +: 8] <= r_wdata;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_idx];
        end
    end

    // configuration registers, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir_word   <= '0;
            r_super_mode <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_DIR_WORD:   r_dir_word   <= i_cfg_data;
                CFG_SUPER_MODE: r_super_mode <= i_cfg_data[0];
                default: begin
                    r_dir_word <= r_dir_word;
                end
            endcase
        end
    end

    // handshake side signals
    assign o_in_stall = (r_state != S_IDLE);
    assign out_free   = !o_out_valid || !i_out_stall;

    // sticky error after the current item
    always_comb begin
        if (r_op == OP_CLEAR) begin
            n_err_status = ERR_NONE;
        end else if (r_res_err != ERR_NONE) begin
            n_err_status = r_res_err;
        end else begin
            n_err_status = r_err_status;
        end
    end

    // walk sequencer and response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_idx    <= '0;
            r_err_status <= ERR_NONE;
            o_out_valid  <= 1'b0;
        end else begin
            // drop the beat once taken, unless the response step refills it
            if (o_out_valid && !i_out_stall && (r_state != S_RESP)) begin
                o_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_idx <= r_clr_idx + 1'b1;
                    if (r_clr_idx == LAST_WORD) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    r_op       <= i_in_data.operation;
                    r_laddr    <= i_in_data.address;
                    r_wdata    <= i_in_data.write_data;
                    r_paddr    <= {2'b00, i_in_data.address};
                    r_is_super <= 1'b0;
                    r_no_write <= 1'b0;
                    r_no_exec  <= 1'b0;
                    r_res_data <= '0;
                    r_res_err  <= ERR_NONE;
                    if (i_in_valid) begin
                        if (i_in_data.operation == OP_CLEAR) begin
                            r_state <= S_RESP;
                        end else if (r_dir_word[PG_BIT_ACTIVE]) begin
                            r_state <= S_DIR;
                        end else begin
                            r_state <= S_ACC;
                        end
                    end
                end
                S_DIR: begin
                    if (dir_ok) begin
                        r_state <= S_DIR_WAIT;
                    end else begin
                        r_res_err <= ERR_BOUNDS;
                        r_state   <= S_RESP;
                    end
                end
                S_DIR_WAIT: begin
                    r_is_super <= r_rd_data[PG_BIT_SUPER];
                    r_page     <= r_rd_data[PG_NUM_W-1:0];
                    if (r_rd_data[PG_BIT_ACTIVE]) begin
                        r_state <= S_TBL;
                    end else begin
                        r_state <= S_ACC;
                    end
                end
                S_TBL: begin
                    if (tbl_ok) begin
                        r_state <= S_TBL_WAIT;
                    end else begin
                        r_res_err <= ERR_BOUNDS;
                        r_state   <= S_RESP;
                    end
                end
                S_TBL_WAIT: begin
                    r_no_write <= r_rd_data[PG_BIT_NOWR];
                    r_no_exec  <= r_rd_data[PG_BIT_NOEX];
                    if (r_rd_data[PG_BIT_ACTIVE]) begin
                        r_paddr <= {r_rd_data[PG_NUM_W-1:0], r_laddr[11:0]};
                    end
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_state <= S_RESP;
                    if (acc_is_write) begin
                        if (r_no_write) begin
                            r_res_err <= ERR_WRITE;
                        end else if (!pa_ok) begin
                            r_res_err <= ERR_BOUNDS;
                        end
                    end else if (user_fault) begin
                        r_res_err <= ERR_USER;
                    end else if (exec_fault) begin
                        r_res_err <= ERR_EXEC;
                    end else if (pa_ok) begin
                        r_state <= S_ACC_WAIT;
                    end else begin
                        r_res_err <= ERR_BOUNDS;
                    end
                end
                S_ACC_WAIT: begin
                    r_res_data <= r_rd_data[8*r_paddr[1:0] +: 8];
                    r_state    <= S_RESP;
                end
                S_RESP: begin
                    if (out_free) begin
                        o_out_valid                <= 1'b1;
                        o_out_data.read_data       <= r_res_data;
                        o_out_data.error_code      <= n_err_status;
                        o_out_data.access_faulted  <= (r_res_err != ERR_NONE);
                        r_err_status               <= n_err_status;
                        r_state                    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // no request is taken while the memory is being cleared
    a_clear_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> o_in_stall)
        else $error("request taken during clearing pass");

    // a faulted beat always carries a nonzero error code
    a_fault_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.access_faulted) |-> (o_out_data.error_code != ERR_NONE))
        else $error("faulted beat without error code");

    // byte writes land only inside the memory
    a_write_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> ({1'b0, r_paddr} < MEM_LIMIT))
        else $error("byte write outside memory");

    // a new response beat only comes out of the response step
    a_resp_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_RESP))
        else $error("response beat raised outside response step");

endmodule

>>> test/two_level_page_walk_mmu_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// two_level_page_walk_mmu_test
// Self-checking bench for the page-walk mmu. Builds directory and table
// entries through flat byte writes, then runs directed and random accesses
// under several directory words and privilege settings. A local walk
// predictor with its own memory mirror checks every response beat in order.
// ----------------------------------------------------------------------------
module two_level_page_walk_mmu_test
    import pwmmu_pkg::*;
;

    localparam int MEM_SIZE = int'(MMU_MEM_BYTES);
    localparam longint unsigned PAGE_BYTES = 64'h1000;
    localparam int DRAIN_CYCLES = 12;
    localparam int STALL_LIMIT = 100000;
    localparam int PRINT_LIMIT = 40;

    // register index that maps to nothing
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 8'd2;

    // table layout built during the flat phase
    localparam logic [31:0] DIR_LOW_BASE   = 32'h0000_1000;
    localparam logic [31:0] TBL_A_BASE     = 32'h0000_2000;
    localparam logic [31:0] TBL_B_BASE     = 32'h0000_3000;
    localparam logic [31:0] TOP_ENTRY_ADDR = 32'h0000_FFFC;
    localparam logic [21:0] TBL_A_PAGE     = 22'd2;
    localparam logic [21:0] TBL_B_PAGE     = 22'd3;
    localparam logic [21:0] TOP_PAGE       = 22'd15;
    localparam logic [21:0] PAST_END_PAGE  = 22'd16;
    localparam logic [21:0] MAX_PAGE       = 22'h3F_FFFF;

    // address shapes for random accesses
    typedef enum int {SPAN_FLAT, SPAN_LOW_DIR, SPAN_TOP_DIR} t_span;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    t_mmu_req             i_in_data = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_mmu_rsp             o_out_data;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [31:0]          i_cfg_data = '0;

    // predictor state
    bit [7:0]    shadow_mem [MEM_SIZE];
    logic [2:0]  sticky_err = ERR_NONE;
    logic [31:0] dir_word = '0;
    bit          super_mode = 1'b0;

    t_mmu_req pending_reqs[$];
    t_mmu_rsp expected_rsps[$];

    bit calm = 1'b0;
    int error_count = 0;
    int access_count = 0;
    int fault_count = 0;
    int checked_count = 0;
    int cfg_count = 0;
    int idle_cycles = 0;

    two_level_page_walk_mmu u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        error_count++;
        if (error_count <= PRINT_LIMIT) begin
            $display("[%0t] mismatch on %s: got %h, want %h", $time, what, got, want);
        end
    endtask

    // little-endian entry fetch, refused when any byte lies past the memory
    function automatic bit read_table_word(longint unsigned addr, output logic [31:0] word);
        word = '0;
        if (addr + 4 > MEM_SIZE) return 1'b0;
        word = {shadow_mem[addr + 3], shadow_mem[addr + 2],
                shadow_mem[addr + 1], shadow_mem[addr]};
        return 1'b1;
    endfunction

    // translate, check permissions and perform one access on the mirror
    function automatic t_mmu_rsp predict_access(t_mmu_req req);
        t_mmu_rsp        rsp;
        longint unsigned phys;
        longint unsigned page;
        longint unsigned idx;
        logic [31:0]     dir_ent;
        logic [31:0]     tbl_ent;
        bit              super_only;
        bit              no_write;
        bit              no_exec;
        logic [2:0]      err;
        rsp = '0;
        phys = 64'(req.address);
        super_only = 1'b0;
        no_write = 1'b0;
        no_exec = 1'b0;
        err = ERR_NONE;
        if (req.operation == OP_CLEAR) begin
            sticky_err = ERR_NONE;
            return rsp;
        end
        // directory then table walk
        if (dir_word[PG_BIT_ACTIVE]) begin
            page = 64'(dir_word[PG_NUM_W-1:0]);
            idx = 64'(req.address[31:22]);
            if (!read_table_word(page * PAGE_BYTES + idx * 4, dir_ent)) begin
                err = ERR_BOUNDS;
            end else begin
                super_only = dir_ent[PG_BIT_SUPER];
                if (dir_ent[PG_BIT_ACTIVE]) begin
                    page = 64'(dir_ent[PG_NUM_W-1:0]);
                    idx = 64'(req.address[21:12]);
                    if (!read_table_word(page * PAGE_BYTES + idx * 4, tbl_ent)) begin
                        err = ERR_BOUNDS;
                    end else begin
                        no_exec = tbl_ent[PG_BIT_NOEX];
                        no_write = tbl_ent[PG_BIT_NOWR];
                        if (tbl_ent[PG_BIT_ACTIVE]) begin
                            page = 64'(tbl_ent[PG_NUM_W-1:0]);
                            phys = page * PAGE_BYTES + 64'(req.address[11:0]);
                        end
                    end
                end
            end
        end
        // permission and bounds rules, then the byte access
        if (err == ERR_NONE) begin
            if (req.operation == OP_WRITE) begin
                if (no_write) err = ERR_WRITE;
                else if (phys < MEM_SIZE) shadow_mem[phys] = req.write_data;
                else err = ERR_BOUNDS;
            end else if (!super_mode && super_only) begin
                err = ERR_USER;
            end else if (req.operation == OP_FETCH && no_exec) begin
                err = ERR_EXEC;
            end else if (phys < MEM_SIZE) begin
                rsp.read_data = shadow_mem[phys];
            end else begin
                err = ERR_BOUNDS;
            end
        end
        if (err != ERR_NONE) sticky_err = err;
        rsp.error_code = sticky_err;
        rsp.access_faulted = (err != ERR_NONE);
        return rsp;
    endfunction

    function automatic logic [31:0] page_entry(logic [21:0] page, bit act, bit sup,
                                               bit nowr, bit noex);
        logic [31:0] ent;
        ent = '0;
        ent[PG_NUM_W-1:0] = page;
        ent[PG_BIT_ACTIVE] = act;
        ent[PG_BIT_SUPER] = sup;
        ent[PG_BIT_NOWR] = nowr;
        ent[PG_BIT_NOEX] = noex;
        return ent;
    endfunction

    // mostly in-range mapped pages, some past the end, junk in the top bits
    function automatic logic [31:0] random_entry();
        logic [31:0] ent;
        logic [21:0] page;
        int          pick;
        pick = $urandom_range(9);
        if (pick < 7) page = 22'($urandom_range(4, 15));
        else if (pick == 7) page = PAST_END_PAGE;
        else if (pick == 8) page = 22'($urandom_range(0, 3));
        else page = MAX_PAGE;
        ent = page_entry(page, $urandom_range(99) < 80, $urandom_range(3) == 0,
                         $urandom_range(3) == 0, $urandom_range(3) == 0);
        ent[31:26] = 6'($urandom);
        return ent;
    endfunction

    function automatic t_mmu_req random_access(t_span span);
        t_mmu_req   req;
        int         pick;
        logic [9:0] dir_idx;
        logic [9:0] tbl_idx;
        logic [11:0] ofs;
        pick = $urandom_range(99);
        req.operation = pick < 35 ? OP_READ : pick < 55 ? OP_FETCH :
                        pick < 90 ? OP_WRITE : OP_CLEAR;
        req.write_data = 8'($urandom_range(255));
        req.address = $urandom;
        pick = $urandom_range(99);
        ofs = pick < 10 ? 12'h000 : pick < 20 ? 12'hFFF : 12'($urandom);
        pick = $urandom_range(99);
        case (span)
            SPAN_FLAT: begin
                if (pick < 80) req.address = $urandom_range(32'h4000, 32'hFFFF);
                else if (pick < 88) req.address = $urandom_range(0, 32'h3FFF);
            end
            SPAN_LOW_DIR: begin
                if (pick < 85) begin
                    pick = $urandom_range(9);
                    dir_idx = pick < 4 ? 10'd0 : pick == 4 ? 10'd1 : pick == 5 ? 10'd2 :
                              pick == 6 ? 10'd3 : pick == 7 ? 10'd4 :
                              pick == 8 ? 10'h3FF : 10'($urandom);
                    pick = $urandom_range(9);
                    tbl_idx = pick < 7 ? 10'($urandom_range(7)) :
                              pick < 9 ? 10'h3FF : 10'($urandom);
                    req.address = {dir_idx, tbl_idx, ofs};
                end
            end
            default: begin
                if (pick < 70) req.address = {10'h3FF, 10'h3FF, ofs};
                else if (pick < 85) req.address = {10'h3FF, 10'($urandom), ofs};
            end
        endcase
        return req;
    endfunction

    task automatic push_access(logic [1:0] op, logic [31:0] addr, logic [7:0] data);
        t_mmu_req req;
        req.operation = op;
        req.address = addr;
        req.write_data = data;
        pending_reqs.push_back(req);
    endtask

    // an entry word goes in as four byte writes, low byte first
    task automatic queue_word(logic [31:0] addr, logic [31:0] value);
        for (int k = 0; k < 4; k++) begin
            push_access(OP_WRITE, addr + k, value[8*k +: 8]);
        end
    endtask

    task automatic run_random(int count, t_span span);
        for (int k = 0; k < count; k++) begin
            pending_reqs.push_back(random_access(span));
        end
    endtask

    // wait until every beat is sent and answered, then let the block go quiet
    task automatic settle();
        do @(negedge i_clk);
        while (pending_reqs.size() != 0 || i_in_valid || expected_rsps.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] index, logic [31:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        cfg_count++;
        case (index)
            CFG_DIR_WORD:   dir_word = value;
            CFG_SUPER_MODE: super_mode = value[0];
            default: ;
        endcase
    endtask

    // request driver: predicts each accepted beat, then offers the next one
    always @(posedge i_clk) begin
        t_mmu_rsp rsp;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                rsp = predict_access(i_in_data);
                expected_rsps.push_back(rsp);
                access_count++;
                if (rsp.access_faulted) fault_count++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (pending_reqs.size() != 0 && (calm || $urandom_range(99) >= 23)) begin
                    i_in_valid <= 1'b1;
                    i_in_data <= pending_reqs.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // response monitor with random back-pressure
    always @(posedge i_clk) begin
        t_mmu_rsp want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_rsps.size() == 0) begin
                    report_mismatch("unexpected response beat", 32'(o_out_data), '0);
                end else begin
                    want = expected_rsps.pop_front();
                    checked_count++;
                    if (o_out_data.read_data !== want.read_data)
                        report_mismatch("read_data", 32'(o_out_data.read_data),
                                        32'(want.read_data));
                    if (o_out_data.error_code !== want.error_code)
                        report_mismatch("error_code", 32'(o_out_data.error_code),
                                        32'(want.error_code));
                    if (o_out_data.access_faulted !== want.access_faulted)
                        report_mismatch("access_faulted", 32'(o_out_data.access_faulted),
                                        32'(want.access_faulted));
                end
            end
            i_out_stall <= !calm && ($urandom_range(99) < 23);
        end
    end

    // watchdog on cycles with no beat on any channel
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // stimulus sequence
    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // flat map: edges of memory, bounds and clear
        push_access(OP_READ,  32'h0000_0000, 8'h00);
        push_access(OP_WRITE, 32'h0000_FFFF, 8'hA5);
        push_access(OP_READ,  32'h0000_FFFF, 8'h00);
        push_access(OP_FETCH, 32'h0000_FFFF, 8'hFF);
        push_access(OP_READ,  32'h0001_0000, 8'h00);
        push_access(OP_WRITE, 32'hFFFF_FFFF, 8'h5A);
        push_access(OP_FETCH, 32'hFFFF_FFFF, 8'h00);
        push_access(OP_CLEAR, 32'hFFFF_FFFF, 8'hFF);
        push_access(OP_WRITE, 32'h0000_0000, 8'hFF);
        push_access(OP_READ,  32'h0000_0000, 8'h00);

        // directory at page 1
        queue_word(DIR_LOW_BASE + 0 * 4, page_entry(TBL_A_PAGE, 1, 0, 0, 0));
        queue_word(DIR_LOW_BASE + 1 * 4, page_entry(TBL_B_PAGE, 1, 1, 0, 0));
        queue_word(DIR_LOW_BASE + 2 * 4, page_entry(MAX_PAGE, 1, 0, 0, 0));
        queue_word(DIR_LOW_BASE + 3 * 4, page_entry(22'd0, 0, 1, 0, 0));
        queue_word(DIR_LOW_BASE + 4 * 4, page_entry(PAST_END_PAGE, 1, 0, 0, 0));
        queue_word(DIR_LOW_BASE + 32'h3FF * 4, page_entry(TBL_A_PAGE, 1, 0, 1, 1));
        // first table: one entry per permission case
        queue_word(TBL_A_BASE + 0 * 4, page_entry(22'd4, 1, 0, 0, 0));
        queue_word(TBL_A_BASE + 1 * 4, page_entry(22'd5, 1, 0, 1, 0));
        queue_word(TBL_A_BASE + 2 * 4, page_entry(22'd6, 1, 0, 0, 1));
        queue_word(TBL_A_BASE + 3 * 4, page_entry(22'd9, 0, 0, 1, 1));
        queue_word(TBL_A_BASE + 4 * 4, page_entry(PAST_END_PAGE, 1, 0, 0, 0));
        queue_word(TBL_A_BASE + 5 * 4, page_entry(TOP_PAGE, 1, 0, 0, 0));
        queue_word(TBL_A_BASE + 32'h3FF * 4, page_entry(22'd7, 1, 0, 0, 0));
        queue_word(TBL_A_BASE + 6 * 4, random_entry());
        queue_word(TBL_A_BASE + 7 * 4, random_entry());
        // second table: random entries
        for (int k = 0; k < 8; k++) begin
            queue_word(TBL_B_BASE + k * 4, random_entry());
        end
        queue_word(TBL_B_BASE + 32'h3FF * 4, random_entry());
        // last word of memory serves as both directory and table entry
        queue_word(TOP_ENTRY_ADDR, page_entry(TOP_PAGE, 1, 0, 0, 0));
        settle();

        // paging on, user mode, junk above bit 0 of the mode register
        write_register(CFG_DIR_WORD, 32'h0040_0001);
        write_register(CFG_SUPER_MODE, 32'hFFFF_FFFE);
        push_access(OP_READ,  32'h0000_0123, 8'h00);
        push_access(OP_WRITE, 32'h0000_1FFF, 8'h11);
        push_access(OP_FETCH, 32'h0000_2000, 8'h00);
        push_access(OP_READ,  32'h0000_2000, 8'h00);
        push_access(OP_WRITE, 32'h0000_3FFF, 8'h22);
        push_access(OP_READ,  32'h0000_3010, 8'h00);
        push_access(OP_FETCH, 32'h0000_3010, 8'h00);
        push_access(OP_READ,  32'h0000_4000, 8'h00);
        push_access(OP_READ,  32'h0000_5FFF, 8'h00);
        push_access(OP_READ,  32'h0040_0000, 8'h00);
        push_access(OP_WRITE, 32'h0040_0000, 8'h33);
        push_access(OP_FETCH, 32'h0040_0000, 8'h00);
        push_access(OP_READ,  32'h0080_0000, 8'h00);
        push_access(OP_WRITE, 32'h0080_0000, 8'h44);
        push_access(OP_READ,  32'h00C0_0000, 8'h00);
        push_access(OP_WRITE, 32'h00C0_0000, 8'h55);
        push_access(OP_READ,  32'h0100_0000, 8'h00);
        push_access(OP_READ,  32'hFFC0_0000, 8'h00);
        push_access(OP_READ,  32'hFFFF_F000, 8'h00);
        push_access(OP_CLEAR, 32'h0000_0000, 8'h00);
        run_random(60, SPAN_LOW_DIR);
        settle();

        // supervisor mode, no idling on either side
        write_register(CFG_SUPER_MODE, 32'h0000_0001);
        calm = 1'b1;
        push_access(OP_READ,  32'h0040_0000, 8'h00);
        push_access(OP_FETCH, 32'h00C0_0000, 8'h00);
        run_random(90, SPAN_LOW_DIR);
        settle();
        calm = 1'b0;

        // directory in the last page of memory
        write_register(CFG_DIR_WORD, 32'h0040_000F);
        run_random(40, SPAN_TOP_DIR);
        settle();

        // all ones: directory far past the memory
        write_register(CFG_DIR_WORD, 32'hFFFF_FFFF);
        run_random(20, SPAN_LOW_DIR);
        settle();

        // paging off with every other bit set, user mode, dead register index
        write_register(CFG_DIR_WORD, 32'hFFBF_FFFF);
        write_register(CFG_SUPER_MODE, 32'h0000_0000);
        write_register(CFG_UNUSED_IDX, $urandom);
        run_random(60, SPAN_FLAT);
        settle();

        // back to the low directory with junk in the upper bits
        write_register(CFG_DIR_WORD, 32'hFF40_0001);
        write_register(CFG_SUPER_MODE, 32'h8000_0001);
        run_random(60, SPAN_LOW_DIR);
        settle();

        if (expected_rsps.size() != 0) begin
            report_mismatch("missing response beats", expected_rsps.size(), '0);
        end
        $display("Run covered %0d accesses, %0d of them faulting, across %0d register writes.",
                 access_count, fault_count, cfg_count);
        $display("%0d response beats compared against the walk predictor, %0d mismatches.",
                 checked_count, error_count);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
